// ===== sv/pla_pkg.sv =====
// Shared constants and state types for the polyline length accumulator.
`default_nettype none

package pla_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int FIELD_W         = 16;
	localparam int LEN_W           = 32;
	localparam int CNT_W           = 16;
	localparam int IN_DATA_W       = 2 * FIELD_W;
	localparam int IN_USER_W       = 1;
	localparam int OUT_DATA_W      = LEN_W + CNT_W;

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		TS_IDLE,
		TS_SEG,
		TS_CLOSE,
		TS_EMIT
	} top_state_t;

	typedef enum logic [1:0] {
		SG_IDLE,
		SG_MUL,
		SG_SUM,
		SG_ROOT
	} seg_state_t;

endpackage

`default_nettype wire

// ===== sv/pla_seg.sv =====
// Bit-serial segment length unit: shift-add squaring and digit-by-digit square root.
`default_nettype none

module pla_seg #(
	parameter int COORD_WIDTH = pla_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by,
	output logic                          done,
	output logic        [COORD_WIDTH:0]   len
);

	import pla_pkg::*;

	localparam int DW    = COORD_WIDTH + 1;
	localparam int SW    = 2 * DW;
	localparam int STP_W = $clog2(DW);

	seg_state_t state_q, state_d;

	logic signed [DW-1:0] dx_s, dy_s;
	logic        [DW-1:0] dx_mag, dy_mag;
	logic        [DW-1:0] mcx_q, mcy_q;
	logic        [SW-1:0] px_q, py_q, rad_q;
	logic        [DW+1:0] rem_q;
	logic        [DW-1:0] root_q;
	logic        [STP_W-1:0] cnt_q;
	logic                 done_q;

	logic                 mul_en, sum_en, root_en, last_step;
	logic        [DW:0]   sumx, sumy;
	logic        [DW+3:0] remx, trial, rdiff;
	logic                 ge;

	// magnitudes of the coordinate differences
	assign dx_s   = DW'(bx) - DW'(ax);
	assign dy_s   = DW'(by) - DW'(ay);
	assign dx_mag = dx_s[DW-1] ? DW'(-dx_s) : DW'(dx_s);
	assign dy_mag = dy_s[DW-1] ? DW'(-dy_s) : DW'(dy_s);

	// one multiplier bit per cycle, product shifts right
	assign sumx = {1'b0, px_q[SW-1:DW]} + (px_q[0] ? {1'b0, mcx_q} : '0);
	assign sumy = {1'b0, py_q[SW-1:DW]} + (py_q[0] ? {1'b0, mcy_q} : '0);

	// two radicand bits per cycle, one root bit out
	assign remx  = {rem_q, rad_q[SW-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = remx >= trial;
	assign rdiff = remx - trial;

	assign last_step = (cnt_q == '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			SG_IDLE: if (start) state_d = SG_MUL;
			SG_MUL:  if (last_step) state_d = SG_SUM;
			SG_SUM:  state_d = SG_ROOT;
			SG_ROOT: if (last_step) state_d = SG_IDLE;
			default: state_d = SG_IDLE;
		endcase
	end

	always_comb begin
		mul_en  = 1'b0;
		sum_en  = 1'b0;
		root_en = 1'b0;
		case (state_q)
			SG_MUL:  mul_en  = 1'b1;
			SG_SUM:  sum_en  = 1'b1;
			SG_ROOT: root_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SG_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= root_en && last_step;
			if ((state_q == SG_IDLE && start) || sum_en) begin
				cnt_q <= STP_W'(DW - 1);
			end else if (mul_en || root_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SG_IDLE && start) begin
			mcx_q <= dx_mag;
			mcy_q <= dy_mag;
			px_q  <= {{DW{1'b0}}, dx_mag};
			py_q  <= {{DW{1'b0}}, dy_mag};
		end else if (mul_en) begin
			px_q <= {sumx, px_q[DW-1:1]};
			py_q <= {sumy, py_q[DW-1:1]};
		end
		if (sum_en) begin
			// sum of squares stays below 2^(SW-1)
			rad_q  <= SW'(px_q + py_q);
			rem_q  <= '0;
			root_q <= '0;
		end else if (root_en) begin
			rad_q  <= {rad_q[SW-3:0], 2'b00};
			rem_q  <= ge ? rdiff[DW+1:0] : remx[DW+1:0];
			root_q <= {root_q[DW-2:0], ge};
		end
	end

	assign done = done_q;
	assign len  = root_q;

endmodule

`default_nettype wire

// ===== sv/polyline_length_accumulator_unit.sv =====
// Top level of the polyline length accumulator: path state, handshakes and result register.
`default_nettype none

// Takes the points of a path one word at a time and returns one word per path
// holding the summed Euclidean length (floored square root of each segment,
// in whole coordinate units, saturating at 2^32-1) and the point count
// (saturating at 65535). Mark the final point with s_tlast; s_tuser[0] on that
// word closes the path back to its first point. A one-point path returns
// length 0. The first point of a path is simply stored. Every later point
// runs one segment through the bit-serial length unit: capture, shift-add
// squaring, adding the squares, square root and accumulation, and no new
// point is taken until that segment is done. The closing segment of a closed
// path starts on the cycle the previous segment finishes, and the result is
// then handed to the output register once that register is free. The result
// waits in its own register, so the next path can start while it is still
// held on m_tdata.
module polyline_length_accumulator_unit #(
	parameter int COORD_WIDTH = pla_pkg::COORD_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pla_pkg::IN_DATA_W-1:0]   s_tdata,   // x_coord, y_coord
	input  logic                            s_tlast,   // last_point
	input  logic [pla_pkg::IN_USER_W-1:0]   s_tuser,   // closed_path
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pla_pkg::OUT_DATA_W-1:0]  m_tdata    // total length, point count
);

	import pla_pkg::*;

	localparam int RW = COORD_WIDTH + 1;
	localparam int AW = ((RW > LEN_W) ? RW : LEN_W) + 1;

	top_state_t state_q, state_d;

	logic signed [COORD_WIDTH-1:0] in_x, in_y;
	logic signed [COORD_WIDTH-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [COORD_WIDTH-1:0] seg_bx, seg_by;
	logic        [LEN_W-1:0]       length_sum_q, len_sat;
	logic        [CNT_W-1:0]       points_seen_q;
	logic                          last_q, closed_q;
	logic        [LEN_W-1:0]       out_len_q;
	logic        [CNT_W-1:0]       out_cnt_q;
	logic                          out_valid_q;

	logic                          in_acc, need_seg, seg_start, seg_done, emit_en, out_free;
	logic        [RW-1:0]          seg_len;
	logic        [AW-1:0]          len_add;

	// low COORD_WIDTH bits of each field, two's complement
	assign in_x = COORD_WIDTH'(s_tdata[FIELD_W-1:0]);
	assign in_y = COORD_WIDTH'(s_tdata[2*FIELD_W-1:FIELD_W]);

	assign in_acc   = s_tvalid && s_tready;
	assign need_seg = (points_seen_q != '0);
	assign out_free = !out_valid_q || m_tready;

	// a regular segment runs previous to incoming point; the closing one runs
	// last point (now in prev) back to the first
	assign seg_bx = (state_q == TS_IDLE) ? in_x : first_x_q;
	assign seg_by = (state_q == TS_IDLE) ? in_y : first_y_q;

	pla_seg #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_seg (
		.clk   (clk),
		.arst_n(arst_n),
		.start (seg_start),
		.ax    (prev_x_q),
		.ay    (prev_y_q),
		.bx    (seg_bx),
		.by    (seg_by),
		.done  (seg_done),
		.len   (seg_len)
	);

	assign len_add = AW'(length_sum_q) + AW'(seg_len);
	assign len_sat = (len_add > AW'(LEN_MAX)) ? LEN_MAX : len_add[LEN_W-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			TS_IDLE: begin
				if (in_acc) begin
					if (need_seg) state_d = TS_SEG;
					else if (s_tlast) state_d = TS_EMIT;
				end
			end
			TS_SEG: begin
				if (seg_done) begin
					if (last_q && closed_q) state_d = TS_CLOSE;
					else if (last_q) state_d = TS_EMIT;
					else state_d = TS_IDLE;
				end
			end
			TS_CLOSE: if (seg_done) state_d = TS_EMIT;
			TS_EMIT:  if (out_free) state_d = TS_IDLE;
			default:  state_d = TS_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		seg_start = 1'b0;
		emit_en   = 1'b0;
		case (state_q)
			TS_IDLE: begin
				s_tready  = 1'b1;
				seg_start = s_tvalid && need_seg;
			end
			TS_SEG:  seg_start = seg_done && last_q && closed_q;
			TS_EMIT: emit_en   = out_free;
			default: ;
		endcase
	end

	// control state and the running path figures
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= TS_IDLE;
			length_sum_q  <= '0;
			points_seen_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc && points_seen_q != CNT_MAX) begin
				points_seen_q <= points_seen_q + 1'b1;
			end
			if (seg_done) begin
				length_sum_q <= len_sat;
			end
			if (emit_en) begin
				// drop the path, start the next from scratch
				length_sum_q  <= '0;
				points_seen_q <= '0;
				out_valid_q   <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// point payload and result word; no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			prev_x_q <= in_x;
			prev_y_q <= in_y;
			last_q   <= s_tlast;
			closed_q <= s_tuser[0];
			if (!need_seg) begin
				first_x_q <= in_x;
				first_y_q <= in_y;
			end
		end
		if (emit_en) begin
			out_len_q <= length_sum_q;
			out_cnt_q <= points_seen_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_cnt_q, out_len_q};

endmodule

`default_nettype wire
